### rtl/miq_pkg.sv
// shared types and constants for the middle insert queue
// no dependencies; imported by every module of the block
`default_nettype none

package miq_pkg;

  // sizes
  localparam int CAPACITY   = 1024;
  localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int ID_W       = 16;
  localparam int PTR_W      = $clog2(HALF_DEPTH);
  localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
  localparam int LEN_W      = 11;

  // request codes; any code with the high bit set is a pop
  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_INSERT  = 2'd1;
  localparam logic [1:0] ACT_POP     = 2'd2;
  localparam int         ACT_POP_BIT = 1;

  // result status codes
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // request transaction
  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] entry_id;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [ID_W-1:0]  served_id;
    status_t          status;
    logic [LEN_W-1:0] queue_length;
  } rsp_t;

  // controller states
  typedef enum logic {
    CS_IDLE,
    CS_FINISH
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic finish;
  } miq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
  } miq_stat_t;

endpackage

`default_nettype wire

### rtl/miq_ctrl.sv
// sequencing controller for the middle insert queue
// depends on miq_pkg; drives the datapath through miq_cmd_t
`default_nettype none

module miq_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  miq_pkg::miq_stat_t  stat,
  output miq_pkg::miq_cmd_t   cmd
);
  import miq_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_FINISH;
      end
      CS_FINISH: begin
        if (stat.slot_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      CS_FINISH: begin
        cmd.finish = stat.slot_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

### rtl/miq_datapath.sv
// half stores, ring pointers and result register of the middle insert queue
// depends on miq_pkg; commanded by miq_ctrl
`default_nettype none

module miq_datapath (
  input  wire                clk,
  input  wire                rst_n,
  input  miq_pkg::req_t      in_data,
  input  miq_pkg::miq_cmd_t  cmd,
  output miq_pkg::miq_stat_t stat,
  output logic               out_valid,
  input  wire                out_stall,
  output miq_pkg::rsp_t      out_data
);
  import miq_pkg::*;

  // half stores
  logic [ID_W-1:0] front_mem [HALF_DEPTH];
  logic [ID_W-1:0] back_mem  [HALF_DEPTH];

  // pointers and occupancies
  logic [PTR_W-1:0] fhead_r, fhead_nxt;
  logic [PTR_W-1:0] bhead_r, bhead_nxt;
  logic [CNT_W-1:0] fcount_r, fcount_nxt;
  logic [CNT_W-1:0] bcount_r, bcount_nxt;
  logic             odd_r, odd_nxt;

  // per-request state carried to the finish cycle
  logic             move_r, move_nxt;
  logic             pop_ok_r, pop_ok_nxt;
  status_t          status_r, status_nxt;

  // registered read data
  logic [ID_W-1:0]  front_rd_r;
  logic [ID_W-1:0]  back_rd_r;

  // result register
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_data_r, out_data_nxt;

  // store write ports
  logic             fwe;
  logic [PTR_W-1:0] fwaddr;
  logic [ID_W-1:0]  fwdata;
  logic             bwe;
  logic [PTR_W-1:0] bwaddr;

  // request decode
  logic [LEN_W-1:0] length;
  logic             is_pop;
  logic             is_push;
  logic             full;
  logic [PTR_W-1:0] ftail;
  logic [PTR_W-1:0] btail;

  assign length  = LEN_W'(fcount_r) + LEN_W'(bcount_r);
  assign is_pop  = in_data.action[ACT_POP_BIT];
  assign is_push = (in_data.action == ACT_PUSH);
  assign full    = (length >= LEN_W'(CAPACITY));
  assign ftail   = fhead_r + fcount_r[PTR_W-1:0];
  assign btail   = bhead_r + bcount_r[PTR_W-1:0];

  // result slot frees when empty or being taken
  assign stat.slot_free = !out_valid_r || !out_stall;

  // next state of pointers and write ports
  always_comb begin
    fhead_nxt  = fhead_r;
    bhead_nxt  = bhead_r;
    fcount_nxt = fcount_r;
    bcount_nxt = bcount_r;
    odd_nxt    = odd_r;
    move_nxt   = move_r;
    pop_ok_nxt = pop_ok_r;
    status_nxt = status_r;
    fwe        = 1'b0;
    fwaddr     = ftail;
    fwdata     = in_data.entry_id;
    bwe        = 1'b0;
    bwaddr     = btail;
    if (cmd.accept) begin
      move_nxt   = 1'b0;
      pop_ok_nxt = 1'b0;
      if (is_pop) begin
        if (fcount_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          // head entry is read this cycle; back head refills front when even
          pop_ok_nxt = 1'b1;
          status_nxt = ST_SERVED;
          fhead_nxt  = fhead_r + PTR_W'(1);
          fcount_nxt = fcount_r - CNT_W'(1);
          odd_nxt    = !odd_r;
          move_nxt   = !odd_r && (bcount_r != '0);
        end
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_ACCEPTED;
        odd_nxt    = !odd_r;
        if (is_push) begin
          if (length == '0) begin
            // lone entry goes straight to the front half
            fwe        = 1'b1;
            fcount_nxt = fcount_r + CNT_W'(1);
          end else begin
            bwe        = 1'b1;
            bcount_nxt = bcount_r + CNT_W'(1);
            move_nxt   = !odd_r;
          end
        end else if (!odd_r) begin
          // middle insert on even length: tail of front half
          fwe        = 1'b1;
          fcount_nxt = fcount_r + CNT_W'(1);
        end else begin
          // middle insert on odd length: new head of back half
          bwe        = 1'b1;
          bwaddr     = bhead_r - PTR_W'(1);
          bhead_nxt  = bhead_r - PTR_W'(1);
          bcount_nxt = bcount_r + CNT_W'(1);
        end
      end
    end else if (cmd.finish && move_r) begin
      // rebalance: back head moves to front tail
      fwe        = 1'b1;
      fwdata     = back_rd_r;
      fcount_nxt = fcount_r + CNT_W'(1);
      bhead_nxt  = bhead_r + PTR_W'(1);
      bcount_nxt = bcount_r - CNT_W'(1);
    end
  end

  // result register next value
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.finish) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.served_id    = pop_ok_r ? front_rd_r : '0;
      out_data_nxt.status       = status_r;
      out_data_nxt.queue_length = length;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fhead_r     <= '0;
      bhead_r     <= '0;
      fcount_r    <= '0;
      bcount_r    <= '0;
      odd_r       <= 1'b0;
      move_r      <= 1'b0;
      pop_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fhead_r     <= fhead_nxt;
      bhead_r     <= bhead_nxt;
      fcount_r    <= fcount_nxt;
      bcount_r    <= bcount_nxt;
      odd_r       <= odd_nxt;
      move_r      <= move_nxt;
      pop_ok_r    <= pop_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // front half store
  always_ff @(posedge clk) begin
    if (fwe) front_mem[fwaddr] <= fwdata;
    if (cmd.accept) front_rd_r <= front_mem[fhead_r];
  end

  // back half store
  always_ff @(posedge clk) begin
    if (bwe) back_mem[bwaddr] <= in_data.entry_id;
    if (cmd.accept) back_rd_r <= back_mem[bhead_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/middle_insert_queue.sv
// top level of the middle insert queue
// depends on miq_pkg, miq_ctrl and miq_datapath
`default_nettype none

// Queue of 16-bit entry identifiers with push at the tail, insert at the middle
// (just behind the center on odd length) and pop from the head, one result per
// request. The queue is two 512-entry ring stores with one write and one
// registered read each; the front half holds as many entries as the back half
// or one more. A request passes the idle and finish states of the controller: in idle
// the accept does the store write and reads both half heads, and in finish one entry
// moves from the back half to the front half when needed and the result register
// loads. A new request is taken only once the last one has finished; a stalled
// result holds the block in its finish state. The stores need no clearing after
// reset, so the first request is taken right away.
module middle_insert_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  miq_pkg::req_t  in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output miq_pkg::rsp_t  out_data
);
  import miq_pkg::*;

  miq_cmd_t  cmd;
  miq_stat_t stat;

  // controller
  miq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  miq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/miq_checker.sv
// port-level checks for the middle insert queue
// depends on miq_pkg; bound to middle_insert_queue
`default_nettype none

module miq_checker (
  input wire           clk,
  input wire           rst_n,
  input wire           in_valid,
  input wire           in_stall,
  input miq_pkg::req_t in_data,
  input wire           out_valid,
  input wire           out_stall,
  input miq_pkg::rsp_t out_data
);
  import miq_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while another is in flight");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // empty pop reports an empty queue and no identifier
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY) |->
      (out_data.served_id == '0 && out_data.queue_length == '0))
    else $error("pop on empty with nonzero fields");

  // push or insert on a full queue reports a full queue and no identifier
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |->
      (out_data.queue_length == LEN_W'(CAPACITY) && out_data.served_id == '0))
    else $error("push on full with wrong length");

endmodule

bind middle_insert_queue miq_checker u_miq_checker (.*);

`default_nettype wire

### dv/middle_insert_queue_test.sv
// self-checking testbench for the middle insert queue
// depends on miq_pkg and the middle_insert_queue top level

module middle_insert_queue_test;
  import miq_pkg::*;

  // undefined action code, decoded as a pop by its high bit
  localparam logic [1:0] ACT_UNDEF = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ROWS = 25;
  localparam int EXP_DEPTH = 8;
  localparam int EXP_W = 3;

  // one line of the directed table; known marks a hand-written result
  typedef struct packed {
    req_t req;
    logic known;
    rsp_t rsp;
  } stim_row_t;

  localparam stim_row_t DIRECTED [ROWS] = '{
    '{'{ACT_POP, 16'h0000}, 1'b1, '{16'h0000, ST_EMPTY, 11'd0}},
    '{'{ACT_UNDEF, 16'hFFFF}, 1'b1, '{16'h0000, ST_EMPTY, 11'd0}},
    '{'{ACT_PUSH, 16'h0000}, 1'b1, '{16'h0000, ST_ACCEPTED, 11'd1}},
    '{'{ACT_PUSH, 16'hFFFF}, 1'b1, '{16'h0000, ST_ACCEPTED, 11'd2}},
    '{'{ACT_INSERT, 16'h1234}, 1'b1, '{16'h0000, ST_ACCEPTED, 11'd3}},
    '{'{ACT_INSERT, 16'h5555}, 1'b1, '{16'h0000, ST_ACCEPTED, 11'd4}},
    '{'{ACT_POP, 16'h0000}, 1'b1, '{16'h0000, ST_SERVED, 11'd3}},
    '{'{ACT_UNDEF, 16'hAAAA}, 1'b1, '{16'h1234, ST_SERVED, 11'd2}},
    '{'{ACT_POP, 16'h0000}, 1'b0, '0},
    '{'{ACT_POP, 16'hFFFF}, 1'b0, '0},
    '{'{ACT_POP, 16'h0000}, 1'b1, '{16'h0000, ST_EMPTY, 11'd0}},
    '{'{ACT_INSERT, 16'h8001}, 1'b1, '{16'h0000, ST_ACCEPTED, 11'd1}},
    '{'{ACT_PUSH, 16'h7FFE}, 1'b0, '0},
    '{'{ACT_INSERT, 16'h00FF}, 1'b0, '0},
    '{'{ACT_INSERT, 16'hFF00}, 1'b0, '0},
    '{'{ACT_PUSH, 16'h5A5A}, 1'b0, '0},
    '{'{ACT_UNDEF, 16'h0000}, 1'b0, '0},
    '{'{ACT_POP, 16'hC3C3}, 1'b0, '0},
    '{'{ACT_INSERT, 16'hA5A5}, 1'b0, '0},
    '{'{ACT_PUSH, 16'h0001}, 1'b0, '0},
    '{'{ACT_POP, 16'h0000}, 1'b0, '0},
    '{'{ACT_UNDEF, 16'h0000}, 1'b0, '0},
    '{'{ACT_POP, 16'h0000}, 1'b0, '0},
    '{'{ACT_POP, 16'h0000}, 1'b0, '0},
    '{'{ACT_POP, 16'h0000}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  // hand-written result that goes with the transaction being offered
  logic row_known;
  rsp_t row_rsp;

  // phase controls
  logic calm = 1'b0;
  logic hold_go = 1'b0;

  int mismatches = 0;
  int sent_total = 0;
  int results_seen = 0;
  int stuck = 0;

  // queue image: two ring halves, front holds as many as back or one more
  logic [ID_W-1:0] front_ids [HALF_DEPTH];
  logic [ID_W-1:0] back_ids [HALF_DEPTH];
  logic [PTR_W-1:0] front_rd = '0;
  logic [PTR_W-1:0] back_rd = '0;
  logic [CNT_W-1:0] front_cnt = '0;
  logic [CNT_W-1:0] back_cnt = '0;
  logic odd_len = 1'b0;

  // expected results waiting for their transaction on the result side
  rsp_t exp_fifo [EXP_DEPTH];
  logic [EXP_W-1:0] exp_wr = '0;
  logic [EXP_W-1:0] exp_rd = '0;
  int exp_count = 0;

  middle_insert_queue i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // move the oldest back entry to the tail of the front half
  function automatic void move_back_head();
    if (back_cnt != 0) begin
      front_ids[front_rd + PTR_W'(front_cnt)] = back_ids[back_rd];
      back_rd = back_rd + PTR_W'(1);
      back_cnt = back_cnt - CNT_W'(1);
      front_cnt = front_cnt + CNT_W'(1);
    end
  endfunction

  // apply one request to the queue image and return its result
  function automatic rsp_t queue_result(input req_t r);
    rsp_t res;
    int total;
    res = '0;
    total = int'(front_cnt) + int'(back_cnt);
    if (r.action[ACT_POP_BIT]) begin
      if (front_cnt == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.served_id = front_ids[front_rd];
        front_rd = front_rd + PTR_W'(1);
        front_cnt = front_cnt - CNT_W'(1);
        odd_len = !odd_len;
        if (odd_len) move_back_head();
        res.status = ST_SERVED;
      end
    end else if (total >= CAPACITY) begin
      res.status = ST_FULL;
    end else begin
      odd_len = !odd_len;
      if (r.action == ACT_PUSH) begin
        back_ids[back_rd + PTR_W'(back_cnt)] = r.entry_id;
        back_cnt = back_cnt + CNT_W'(1);
        if (odd_len) move_back_head();
      end else if (odd_len) begin
        front_ids[front_rd + PTR_W'(front_cnt)] = r.entry_id;
        front_cnt = front_cnt + CNT_W'(1);
      end else begin
        back_rd = back_rd - PTR_W'(1);
        back_ids[back_rd] = r.entry_id;
        back_cnt = back_cnt + CNT_W'(1);
      end
      res.status = ST_ACCEPTED;
    end
    res.queue_length = LEN_W'(int'(front_cnt) + int'(back_cnt));
    return res;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // random request; pops split between the defined and the undefined code
  function automatic req_t random_req(input int push_pct, input int insert_pct);
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.entry_id = ID_W'($urandom);
    if (pick < push_pct) r.action = ACT_PUSH;
    else if (pick < push_pct + insert_pct) r.action = ACT_INSERT;
    else r.action = $urandom_range(0, 1) ? ACT_POP : ACT_UNDEF;
    return r;
  endfunction

  // offer one transaction and wait until it is taken
  task automatic send_req(input req_t r, input logic known, input rsp_t rsp);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    row_known <= known;
    row_rsp <= rsp;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent_total++;
  endtask

  // predict on every accepted request, check every accepted result
  always @(posedge clk) begin : scoreboard
    rsp_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = queue_result(in_data);
        if (row_known) want = row_rsp;
        exp_fifo[exp_wr] = want;
        exp_wr = exp_wr + EXP_W'(1);
        exp_count++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (exp_count == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
          mismatches++;
        end else begin
          want = exp_fifo[exp_rd];
          exp_rd = exp_rd + EXP_W'(1);
          exp_count--;
          check_field("served_id", want.served_id, out_data.served_id);
          check_field("status", want.status, out_data.status);
          check_field("queue_length", want.queue_length, out_data.queue_length);
        end
      end
    end
  end

  // result side: random stalls, one long hold while the sender keeps offering
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stuck);
      $display("middle_insert_queue_test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    in_valid = 1'b0;
    in_data = '0;
    row_known = 1'b0;
    row_rsp = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < ROWS; i++) begin
      send_req(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].rsp);
    end

    // mixed traffic, first stretch without any idling
    calm <= 1'b1;
    for (int i = 0; i < 150; i++) send_req(random_req(30, 30), 1'b0, '0);
    calm <= 1'b0;
    for (int i = 0; i < 150; i++) send_req(random_req(30, 30), 1'b0, '0);

    // grow the queue; the result side holds off once at the start of this stretch
    hold_go <= 1'b1;
    for (int i = 0; i < 180; i++) send_req(random_req(60, 35), 1'b0, '0);

    // drain past empty with a little insert noise
    for (int i = 0; i < 270; i++) send_req(random_req(0, 2), 1'b0, '0);

    // mixed traffic around the empty queue, with slightly more adds than pops
    for (int i = 0; i < 50; i++) send_req(random_req(35, 20), 1'b0, '0);
    in_valid <= 1'b0;

    while (results_seen < sent_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (exp_count != 0) begin
      $display("%0t: %0d results missing, expected %0h, actual none", $time,
               exp_count, exp_fifo[exp_rd]);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("middle_insert_queue_test passed");
    end else begin
      $display("middle_insert_queue_test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/miq_pkg.sv
rtl/miq_ctrl.sv
rtl/miq_datapath.sv
rtl/middle_insert_queue.sv
rtl/miq_checker.sv
dv/middle_insert_queue_test.sv
